// ===== hw/rtl/positional_array_list_defines.svh =====
// ----------------------------------------------------------------------------
// Positional array list: assertion macros
// Shared property forms for the list block's checks.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional array list package
// Request kinds, status codes and the command broadcast to the cell chain.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_ERASE  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_APPEND = 2'd2,
    OP_ERASE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    value;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/pal_cell.sv =====
// ----------------------------------------------------------------------------
// Positional array list: storage cell
// Holds one list entry; loads the new word, takes its left neighbour on an
// insert below it, or its right neighbour on an erase at or below it.
// ----------------------------------------------------------------------------
module pal_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  pal_pkg::cell_cmd_t cmd,
  input  logic [IW-1:0]     target,
  input  pal_pkg::word_t    left_word,
  input  pal_pkg::word_t    right_word,
  output pal_pkg::word_t    entry,
  output pal_pkg::word_t    rd_word
);
  import pal_pkg::*;

  logic hit;
  logic above;

  assign hit     = (target == IW'(IDX));
  assign above   = (IW'(IDX) > target);
  assign rd_word = hit ? entry : '0;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INSERT: begin
        if (hit) begin
          entry <= cmd.value;
        end else if (above) begin
          entry <= left_word;
        end
      end
      OP_APPEND: begin
        if (hit) begin
          entry <= cmd.value;
        end
      end
      OP_ERASE: begin
        if (hit || above) begin
          entry <= right_word;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// Positional array list
// Ordered list of signed words held in a chain of cells, one entry per cell.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one request of kind, position, value.
// Output channel (out_valid / out_stall): one result per request carrying
// read_value, length, is_empty and status.
// Latency: the result is valid the cycle after the request is taken.
// Throughput: one request per cycle when not stalled. Every cell updates at
// the same edge, so an insert or erase moves the whole list at once; a read
// picks its entry through the OR of all cell select outputs in the same cycle.
// Positions are 1-based. Insert takes 1..length+1, erase and read take
// 1..length; anything else returns status range and changes nothing. Insert
// or append on a full list returns status full.
// Reset empties the list (count goes to zero); entry words are not cleared.
// While the receiver stalls, the result register holds and in_stall is
// raised, so no request is taken until the pending result has gone.
// ----------------------------------------------------------------------------
`include "positional_array_list_defines.svh"

module positional_array_list #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic [$clog2(CAPACITY+2)-1:0]     position,
  input  pal_pkg::word_t                    value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pal_pkg::word_t                    read_value,
  output logic [$clog2(CAPACITY+1)-1:0]     length,
  output logic                              is_empty,
  output logic [1:0]                        status
);
  import pal_pkg::*;

  localparam int PW = $clog2(CAPACITY + 2);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic            in_acc;
  logic            out_acc;
  logic [LW-1:0]   count;
  logic [LW-1:0]   count_next;
  kind_t           req_kind;
  status_t         status_c;
  cell_op_t        op;
  cell_cmd_t       cmd;
  logic [IW-1:0]   target;
  logic [PW:0]     pos_ext;
  logic [PW:0]     cnt_ext;
  logic            pos_zero;
  logic            full;
  logic            rd_sel;
  word_t           rd_or;
  word_t           entry   [CAPACITY];
  word_t           rd_word [CAPACITY];

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // request decode and status
  always_comb begin
    req_kind   = kind_t'(kind);
    pos_ext    = (PW+1)'(position);
    cnt_ext    = (PW+1)'(count);
    pos_zero   = (position == '0);
    full       = (count == LW'(CAPACITY));
    status_c   = ST_OK;
    op         = OP_HOLD;
    rd_sel     = 1'b0;
    count_next = count;
    target     = IW'(position - PW'(1));
    case (req_kind)
      KIND_INSERT: begin
        if (pos_zero || (pos_ext > cnt_ext + (PW+1)'(1))) begin
          status_c = ST_RANGE;
        end else if (full) begin
          status_c = ST_FULL;
        end else begin
          op         = OP_INSERT;
          count_next = count + LW'(1);
        end
      end
      KIND_APPEND: begin
        target = IW'(count);
        if (full) begin
          status_c = ST_FULL;
        end else begin
          op         = OP_APPEND;
          count_next = count + LW'(1);
        end
      end
      KIND_ERASE: begin
        if (pos_zero || (pos_ext > cnt_ext)) begin
          status_c = ST_RANGE;
        end else begin
          op         = OP_ERASE;
          count_next = count - LW'(1);
        end
      end
      KIND_READ: begin
        if (pos_zero || (pos_ext > cnt_ext)) begin
          status_c = ST_RANGE;
        end else begin
          rd_sel = 1'b1;
        end
      end
      default: begin
        status_c = ST_RANGE;
      end
    endcase
    if (!in_acc) begin
      op = OP_HOLD;
    end
    cmd.op    = op;
    cmd.value = value;
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_word;
    word_t right_word;
    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = entry[i+1];
    end
    pal_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .target     (target),
      .left_word  (left_word),
      .right_word (right_word),
      .entry      (entry[i]),
      .rd_word    (rd_word[i])
    );
  end

  // only the selected cell drives a non-zero word
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_word[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      read_value <= rd_sel ? rd_or : '0;
      length     <= count_next;
      is_empty   <= (count_next == '0);
      status     <= status_c;
    end
  end

  `PAL_ASSERT_NEXT(a_count_hold, !in_acc, $stable(count), "count changed without a request")
  `PAL_ASSERT_NOW(a_full_len, out_valid && (status == ST_FULL), length == LW'(CAPACITY), "full status on a list that is not full")
  `PAL_ASSERT_NOW(a_fail_zero, out_valid && (status != ST_OK), read_value == '0, "read value not zero on a failed request")

endmodule
